[hdl/rtlt_pkg.sv]
// Shared types and codes for the round-trip latency tracker.
package rtlt_pkg;

    localparam int ID_W    = 16;
    localparam int NOW_W   = 63;
    localparam int SAMPLE_W = 32;
    localparam int INDEX_W = 10;

    localparam logic [1:0] OP_PUBLISH  = 2'd0;
    localparam logic [1:0] OP_ACK      = 2'd1;
    localparam logic [1:0] OP_INTERNAL = 2'd2;

    localparam logic KIND_INTERNAL   = 1'b0;
    localparam logic KIND_ROUND_TRIP = 1'b1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic [1:0]                 operation;
        logic [ID_W-1:0]            message_id;
        logic [NOW_W-1:0]           now_us;
        logic signed [SAMPLE_W-1:0] internal_sample_us;
    } t_in_item;

    typedef struct packed {
        logic                       sample_valid;
        logic                       sample_kind;
        logic signed [SAMPLE_W-1:0] sample_us;
        logic [INDEX_W-1:0]         sample_index;
        logic                       ack_matched;
        logic                       capture_done;
    } t_out_item;

    typedef struct packed {
        logic wr_en;
        logic clr_en;
    } t_slot_ctl;

endpackage

[hdl/rtlt_slots.sv]
// Pending-message slot table: id and send-time memories with per-slot live bits.
module rtlt_slots import rtlt_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_slot_ctl           i_ctl,
    input  logic [AW-1:0]       i_wr_addr,
    input  logic [ID_W-1:0]     i_wr_id,
    input  logic [SAMPLE_W-1:0] i_wr_time,
    input  logic [AW-1:0]       i_clr_addr,
    input  logic [AW-1:0]       i_rd_addr,
    output logic [ID_W-1:0]     o_rd_id,
    output logic [SAMPLE_W-1:0] o_rd_time,
    output logic                o_rd_live
);

    logic [ID_W-1:0]     r_id_mem   [DEPTH];
    // Only the low bits of the send time matter, since samples are cut to 32 bits.
    logic [SAMPLE_W-1:0] r_time_mem [DEPTH];
    logic [DEPTH-1:0]    r_live;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_id_mem[i_wr_addr]   <= i_wr_id;
            r_time_mem[i_wr_addr] <= i_wr_time;
        end
        o_rd_id   <= r_id_mem[i_rd_addr];
        o_rd_time <= r_time_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            o_rd_live <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_live[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.clr_en) begin
                r_live[i_clr_addr] <= 1'b0;
            end
            o_rd_live <= r_live[i_rd_addr];
        end
    end

endmodule

[hdl/round_trip_latency_tracker_top.sv]
// Top level of the round-trip latency tracker: sequencer, counters and result register.
// Publish, internal-sample, unused-code and zero-id ack transactions: result in the cycle
// after acceptance, and busy stays low, so one such transaction can enter every cycle.
// Acknowledge with a nonzero id: the slot table is scanned one slot per cycle through
// the single id comparator; a live match clears its slot and ends the scan, and a miss
// ends it after the last slot. Busy is high for the whole scan.
// Synchronous reset frees every slot and clears the pointer, both counts and the strobe.
module round_trip_latency_tracker_top import rtlt_pkg::*; #(
    parameter int PENDING_DEPTH = 32,
    parameter int CAPTURE_LEN   = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output t_out_item o_result,
    output logic      o_result_valid
);

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(CAPTURE_LEN + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(PENDING_DEPTH - 1);
    localparam logic [CW-1:0] CAP       = CW'(CAPTURE_LEN);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [AW-1:0]       r_idx, n_idx;
    logic [AW-1:0]       r_cmp_idx, n_cmp_idx;
    logic                r_cmp_vld, n_cmp_vld;
    logic                r_cmp_last, n_cmp_last;
    logic [ID_W-1:0]     r_ack_id, n_ack_id;
    logic [SAMPLE_W-1:0] r_ack_now, n_ack_now;
    logic [CW-1:0]       r_int_cnt, n_int_cnt;
    logic [CW-1:0]       r_rt_cnt, n_rt_cnt;
    t_out_item           r_result, n_result;
    logic                r_strobe, n_strobe;

    t_slot_ctl           slot_ctl;
    logic [ID_W-1:0]     rd_id;
    logic [SAMPLE_W-1:0] rd_time;
    logic                rd_live;
    logic                accept;
    logic                hit;

    rtlt_slots #(
        .DEPTH (PENDING_DEPTH),
        .AW    (AW)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (slot_ctl),
        .i_wr_addr  (r_ptr),
        .i_wr_id    (i_item.message_id),
        .i_wr_time  (i_item.now_us[SAMPLE_W-1:0]),
        .i_clr_addr (r_cmp_idx),
        .i_rd_addr  (r_idx),
        .o_rd_id    (rd_id),
        .o_rd_time  (rd_time),
        .o_rd_live  (rd_live)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && (r_state == S_IDLE);
    assign hit    = r_cmp_vld && rd_live && (rd_id == r_ack_id);

    always_comb begin
        n_state    = r_state;
        n_ptr      = r_ptr;
        n_idx      = r_idx;
        n_cmp_idx  = r_idx;
        n_cmp_vld  = (r_state == S_SCAN);
        n_cmp_last = (r_idx == LAST_SLOT);
        n_ack_id   = r_ack_id;
        n_ack_now  = r_ack_now;
        n_int_cnt  = r_int_cnt;
        n_rt_cnt   = r_rt_cnt;
        n_result   = r_result;
        n_strobe   = 1'b0;
        slot_ctl   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_result = '0;
                    n_strobe = 1'b1;
                    unique case (i_item.operation)
                        OP_PUBLISH: begin
                            if (i_item.message_id != '0) begin
                                slot_ctl.wr_en = 1'b1;
                                n_ptr = (r_ptr == LAST_SLOT) ? '0 : r_ptr + 1'b1;
                            end
                        end
                        OP_ACK: begin
                            if (i_item.message_id != '0) begin
                                // The result is produced when the scan ends.
                                n_strobe  = 1'b0;
                                n_ack_id  = i_item.message_id;
                                n_ack_now = i_item.now_us[SAMPLE_W-1:0];
                                n_idx     = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        OP_INTERNAL: begin
                            if (r_int_cnt < CAP) begin
                                n_result.sample_valid = 1'b1;
                                n_result.sample_kind  = KIND_INTERNAL;
                                n_result.sample_us    = i_item.internal_sample_us;
                                n_result.sample_index = INDEX_W'(r_int_cnt);
                                n_int_cnt = r_int_cnt + 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_idx = (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
                if (hit || (r_cmp_vld && r_cmp_last)) begin
                    n_result  = '0;
                    n_strobe  = 1'b1;
                    n_state   = S_IDLE;
                    n_cmp_vld = 1'b0;
                    if (hit) begin
                        slot_ctl.clr_en      = 1'b1;
                        n_result.ack_matched = 1'b1;
                        if (r_rt_cnt < CAP) begin
                            n_result.sample_valid = 1'b1;
                            n_result.sample_kind  = KIND_ROUND_TRIP;
                            n_result.sample_us    = $signed(r_ack_now - rd_time);
                            n_result.sample_index = INDEX_W'(r_rt_cnt);
                            n_rt_cnt = r_rt_cnt + 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_result.capture_done = (n_int_cnt >= CAP) && (n_rt_cnt >= CAP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
        end else begin
            r_state   <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_int_cnt <= '0;
            r_rt_cnt  <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_ptr     <= n_ptr;
            r_idx     <= n_idx;
            r_cmp_vld <= n_cmp_vld;
            r_int_cnt <= n_int_cnt;
            r_rt_cnt  <= n_rt_cnt;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_cmp_last <= n_cmp_last;
        r_ack_id   <= n_ack_id;
        r_ack_now  <= n_ack_now;
        r_result   <= n_result;
    end

    assign o_result       = r_result;
    assign o_result_valid = r_strobe;

endmodule
